### design/masked_byte_pattern_search_assert.svh
// Assertion macros for the masked byte pattern search block.
// Included by the modules that check their own logic; uses their clk and rst_n.
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### design/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
// No dependencies.
package mbps_pkg;

  localparam int CFG_INDEX_W       = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int PATTERN_REG_BYTES = 16;
  localparam int LENGTH_W          = 5;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDRESS   = 3'd4;

  // Pattern settings seen by the compare front end.
  typedef struct packed {
    logic [8*PATTERN_REG_BYTES-1:0] pattern;        // byte j in bits 8j+7:8j
    logic [PATTERN_REG_BYTES-1:0]   care_mask;
    logic [LENGTH_W-1:0]            pattern_length;
  } match_cfg_t;

endpackage

### design/mbps_front.sv
// Front end: byte window, masked parallel compare, stream position tracking.
// Depends on mbps_pkg and masked_byte_pattern_search_assert.svh.
`include "masked_byte_pattern_search_assert.svh"

module mbps_front
  import mbps_pkg::*;
#(
  parameter int PATTERN_BYTES = 16,
  parameter int ADDRESS_WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  match_cfg_t               cfg,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output logic                     emit,
  output logic                     found,
  output logic [ADDRESS_WIDTH-1:0] start
);

  localparam int LEN_W = $clog2(PATTERN_BYTES + 1);

  logic [7:0]               window_r   [PATTERN_BYTES];
  logic [7:0]               window_nxt [PATTERN_BYTES];
  logic [7:0]               exp_byte   [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] exp_care;
  logic [LEN_W-1:0]         fill_r, fill_nxt;
  logic [LEN_W-1:0]         len;
  logic [ADDRESS_WIDTH-1:0] pos_r;
  logic                     reported_r;
  logic                     all_ok;

  // Slot 0 takes the new byte; older bytes move up one slot.
  always_comb begin
    window_nxt[0] = data_byte;
    for (int k = 1; k < PATTERN_BYTES; k++) begin
      window_nxt[k] = window_r[k-1];
    end
  end

  // Clamp the programmed length into 1..PATTERN_BYTES.
  always_comb begin
    if (cfg.pattern_length == '0) begin
      len = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > PATTERN_BYTES) begin
      len = LEN_W'(PATTERN_BYTES);
    end else begin
      len = LEN_W'(cfg.pattern_length);
    end
  end

  // Align the pattern to the window: slot k faces pattern byte len-1-k.
  always_comb begin
    int         j;
    logic [3:0] jsel;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      j           = int'(len) - 1 - k;
      jsel        = j[3:0];
      exp_byte[k] = cfg.pattern[{jsel, 3'b000} +: 8];
      exp_care[k] = (j >= 0) && (j < PATTERN_REG_BYTES) && cfg.care_mask[jsel];
    end
  end

  always_comb begin
    all_ok = 1'b1;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      if (exp_care[k] && (exp_byte[k] != window_nxt[k])) begin
        all_ok = 1'b0;
      end
    end
  end

  assign fill_nxt = (fill_r == LEN_W'(PATTERN_BYTES)) ? fill_r : fill_r + LEN_W'(1);
  assign found    = !reported_r && (fill_nxt >= len) && all_ok;
  assign emit     = accept && (found || (last_byte && !reported_r));
  assign start    = pos_r + ADDRESS_WIDTH'(1) - ADDRESS_WIDTH'(len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      pos_r      <= '0;
      reported_r <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        fill_r     <= '0;
        pos_r      <= '0;
        reported_r <= 1'b0;
      end else begin
        fill_r     <= fill_nxt;
        pos_r      <= pos_r + ADDRESS_WIDTH'(1);
        reported_r <= reported_r || found;
      end
    end
  end

  // Stale window slots are masked by the fill count.
  always_ff @(posedge clk) begin
    if (accept) begin
      window_r <= window_nxt;
    end
  end

  `ASSERT_NEXT(a_report_sticks, accept && found && !last_byte, reported_r,
               "match not recorded after found")
  `ASSERT_NEXT(a_last_clears, accept && last_byte, (fill_r == '0) && !reported_r,
               "stream state not cleared after last byte")
  `ASSERT_IMPLY(a_found_full_window, found, fill_nxt >= len,
                "found with window shorter than pattern")

endmodule

### design/mbps_queue.sv
// Short request queue between the compare front end and the result back end.
// Depends on mbps_pkg and masked_byte_pattern_search_assert.svh.
`include "masked_byte_pattern_search_assert.svh"

module mbps_queue
  import mbps_pkg::*;
#(
  parameter int WIDTH = 49
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_IMPLY(a_no_overflow, push, !full, "push into full queue")
  `ASSERT_IMPLY(a_no_underflow, pop, valid, "pop from empty queue")
  `ASSERT_NEXT(a_count_tracks, push && !pop, count_r != '0, "count lost a push")

endmodule

### design/mbps_back.sv
// Back end: forms the result address and holds the result for the receiver.
// Depends on mbps_pkg.
module mbps_back
  import mbps_pkg::*;
#(
  parameter int ADDRESS_WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [ADDRESS_WIDTH-1:0] base_address,
  input  logic                     q_valid,
  input  logic                     q_found,
  input  logic [ADDRESS_WIDTH-1:0] q_start,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_match_found,
  output logic [ADDRESS_WIDTH-1:0] out_match_address
);

  logic                     valid_r;
  logic                     found_r;
  logic [ADDRESS_WIDTH-1:0] address_r, address_nxt;

  assign q_pop       = q_valid && (!valid_r || out_ready);
  assign address_nxt = q_found ? base_address + q_start : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      found_r   <= q_found;
      address_r <= address_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_match_found   = found_r;
  assign out_match_address = address_r;

endmodule

### design/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search block: config registers and wiring.
// Depends on mbps_pkg, mbps_front, mbps_queue and mbps_back.
//
// Usage: program the pattern through the cfg_ write port (pattern_low, pattern_high,
// care_mask, pattern_length, base_address at indexes 0..4), then stream bytes on the
// in_ channel with in_last_byte on the final byte of each stream. Each stream gives one
// result request on the out_ channel: found with base_address plus the match start on
// the first masked match, or not found at the end of a stream without a match.
// Throughput: one byte per cycle while in_ready is high; the masked compare of every
// window slot against the aligned pattern is done in the cycle the byte is taken. A result
// request passes through the queue and then the output register before it appears on
// out_valid.
// Stall: while the receiver holds out_ready low, result requests collect in a
// two-entry queue; bytes keep flowing until the queue is full, then in_ready drops.
// Reset (synchronous, rst_n low): clear the config registers (length 1), the stream
// position, fill count, match flag, queue and out_valid; no clearing pass is needed.
module masked_byte_pattern_search
  import mbps_pkg::*;
#(
  parameter int PATTERN_BYTES = 16,
  parameter int ADDRESS_WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration write port
  input  logic                     cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // byte stream
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last_byte,
  // result requests
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_match_found,
  output logic [ADDRESS_WIDTH-1:0] out_match_address
);

  localparam int Q_WIDTH = ADDRESS_WIDTH + 1;

  match_cfg_t               match_cfg_r;
  logic [ADDRESS_WIDTH-1:0] base_address_r;

  logic                     accept;
  logic                     emit;
  logic                     found;
  logic [ADDRESS_WIDTH-1:0] start;
  logic                     q_full;
  logic                     q_valid;
  logic                     q_pop;
  logic [Q_WIDTH-1:0]       q_data;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_cfg_r.pattern        <= '0;
      match_cfg_r.care_mask      <= '0;
      match_cfg_r.pattern_length <= LENGTH_W'(1);
      base_address_r             <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_LOW:    match_cfg_r.pattern[63:0]   <= cfg_data;
        REG_PATTERN_HIGH:   match_cfg_r.pattern[127:64] <= cfg_data;
        REG_CARE_MASK:      match_cfg_r.care_mask       <= cfg_data[PATTERN_REG_BYTES-1:0];
        REG_PATTERN_LENGTH: match_cfg_r.pattern_length  <= cfg_data[LENGTH_W-1:0];
        REG_BASE_ADDRESS:   base_address_r              <= cfg_data[ADDRESS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Take a byte whenever the queue has room for the request it may cause.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  mbps_front #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (match_cfg_r),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .emit      (emit),
    .found     (found),
    .start     (start)
  );

  // Only bytes that produce a result push a request.
  mbps_queue #(
    .WIDTH (Q_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data ({found, start}),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  mbps_back #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .base_address      (base_address_r),
    .q_valid           (q_valid),
    .q_found           (q_data[Q_WIDTH-1]),
    .q_start           (q_data[ADDRESS_WIDTH-1:0]),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_match_found   (out_match_found),
    .out_match_address (out_match_address)
  );

endmodule

### test/tb.sv
// Self-checking testbench for masked_byte_pattern_search: streams bytes, writes the
// pattern registers between phases and checks every result request against a predictor.
// Depends on mbps_pkg and the design files.
module tb;
  import mbps_pkg::*;

  localparam int WIN_BYTES     = 16;
  localparam int AW            = 48;
  localparam int IDLE_LIMIT    = 1000;  // cycles with no request moving on either side
  localparam int SETTLE_CYCLES = 6;     // let the queue and output register drain, with slack
  localparam int HOLD_CYCLES   = 80;
  localparam int TARGET_BYTES  = 1350;
  localparam int TAIL_BYTES    = 150;
  localparam int MAX_STREAM    = 60;
  localparam int PRINT_LIMIT   = 100;

  typedef logic [AW-1:0] addr_t;

  typedef struct {
    bit    found;
    addr_t addr;
  } scan_result_t;

  typedef enum int {
    STREAM_PLANT,      // pattern placed somewhere in random bytes
    STREAM_NEAR_MISS,  // pattern placed with one byte flipped
    STREAM_NOISE       // random bytes only
  } stream_kind_t;

  // Tracks the scan state of the block and the result requests it still owes.
  class signature_tracker;
    bit [8*WIN_BYTES-1:0] pattern;
    bit [15:0]            care;
    bit [LENGTH_W-1:0]    pat_length = 1;
    addr_t                base;
    bit [7:0]             window [WIN_BYTES];
    addr_t                position;
    bit                   reported;
    int                   fill;
    scan_result_t         pending_hits [$];
    int                   errors;
    int                   found_seen;
    int                   missing_seen;

    function void clear_stream();
      foreach (window[k]) window[k] = 8'h00;
      position = '0;
      reported = 1'b0;
      fill     = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PATTERN_LOW:    pattern[63:0]   = val;
        REG_PATTERN_HIGH:   pattern[127:64] = val;
        REG_CARE_MASK:      care            = val[15:0];
        REG_PATTERN_LENGTH: pat_length      = val[LENGTH_W-1:0];
        REG_BASE_ADDRESS:   base            = val[AW-1:0];
        default: ;
      endcase
    endfunction

    // Length actually compared: zero counts as one, anything past the window is clipped.
    function int active_len();
      if (pat_length == 0) return 1;
      if (pat_length > WIN_BYTES) return WIN_BYTES;
      return int'(pat_length);
    endfunction

    // Shift one accepted byte in and queue the result request it causes, if any.
    function void take_byte(bit [7:0] data, bit last);
      int           len;
      bit           hit;
      scan_result_t r;
      for (int k = WIN_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = data;
      if (fill < WIN_BYTES) fill++;
      if (!reported) begin
        len = active_len();
        if (fill >= len) begin
          hit = 1'b1;
          // Pattern byte j lines up with the byte len-1-j places back; a clear care bit
          // makes it a wildcard.
          for (int j = 0; j < len; j++)
            if (care[j] && pattern[8*j +: 8] != window[len-1-j]) hit = 1'b0;
          if (hit) begin
            r.found  = 1'b1;
            r.addr   = base + position + addr_t'(1) - addr_t'(len);
            reported = 1'b1;
            pending_hits.push_back(r);
          end
        end
      end
      if (last) begin
        if (!reported) begin
          r.found = 1'b0;
          r.addr  = '0;
          pending_hits.push_back(r);
        end
        clear_stream();
      end else begin
        position = position + addr_t'(1);
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_LIMIT) $display("MISMATCH: %s", what);
    endtask

    // Compare one accepted result request with the oldest one owed.
    task match_result(logic found, logic [AW-1:0] addr);
      scan_result_t want;
      if (pending_hits.size() == 0) begin
        report($sformatf("result found=%b addr=%h with none owed", found, addr));
      end else begin
        want = pending_hits.pop_front();
        if (found !== want.found)
          report($sformatf("match_found %b, want %b", found, want.found));
        if (addr !== want.addr)
          report($sformatf("match_address %h, want %h", addr, want.addr));
        if (want.found) found_seen++;
        else missing_seen++;
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_data_byte;
  logic                   in_last_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_match_found;
  logic [AW-1:0]          out_match_address;

  signature_tracker book;
  int               tx_gap_odds;    // 0: sender never idles
  int               rx_stall_odds;  // 0: receiver never stalls
  bit               hold_req;       // ask the receiver for one long hold-off
  int               bytes_sent;
  int               streams_sent;
  int               cfg_writes;
  int               quiet_cycles;

  masked_byte_pattern_search dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_match_found  (out_match_found),
    .out_match_address(out_match_address)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drop valid and put junk on the payload; n sets the length of the pause.
  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid     = 1'b0;
    in_data_byte = 8'($urandom);
    in_last_byte = 1'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Offer one byte request and hold it until the block takes it.
  task automatic send_byte(bit [7:0] data, bit last);
    if (tx_gap_odds != 0 && $urandom_range(tx_gap_odds - 1, 0) == 0)
      pause_sender($urandom_range(1, 18));
    @(negedge clk);
    in_valid     = 1'b1;
    in_data_byte = data;
    in_last_byte = last;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    book.take_byte(data, last);
    bytes_sent++;
  endtask

  // Stop sending and wait until every owed result request has arrived, then let the
  // pipeline settle so a byte with no result is not still in flight.
  task automatic await_drain();
    pause_sender(1);
    while (book.pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    book.set_reg(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Write all five registers; unused upper data bits carry junk.
  task automatic program_all(logic [63:0] pat_lo, logic [63:0] pat_hi, logic [15:0] care,
                             logic [LENGTH_W-1:0] len, logic [AW-1:0] base);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_write(REG_PATTERN_LOW, pat_lo);
    cfg_write(REG_PATTERN_HIGH, pat_hi);
    cfg_write(REG_CARE_MASK, {junk[63:16], care});
    cfg_write(REG_PATTERN_LENGTH, {junk[63:LENGTH_W], len});
    cfg_write(REG_BASE_ADDRESS, {junk[63:AW], base});
  endtask

  task automatic random_config();
    logic [15:0]         care;
    logic [LENGTH_W-1:0] len;
    logic [AW-1:0]       base;
    case ($urandom_range(0, 5))
      0:       care = 16'hFFFF;
      1:       care = 16'h0000;
      2:       care = 16'($urandom & $urandom);
      3:       care = 16'($urandom | $urandom);
      default: care = 16'($urandom);
    endcase
    case ($urandom_range(0, 11))
      0:       len = LENGTH_W'(0);
      1:       len = LENGTH_W'($urandom_range(17, 31));
      2:       len = LENGTH_W'(16);
      3:       len = LENGTH_W'(1);
      default: len = LENGTH_W'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 4))
      0:       base = '0;
      1:       base = '1;
      2:       base = '1 - addr_t'($urandom_range(0, 40));
      default: base = addr_t'({$urandom, $urandom});
    endcase
    program_all({$urandom, $urandom}, {$urandom, $urandom}, care, len, base);
  endtask

  // Build one stream, optionally plant the pattern, and send it with last on the end.
  task automatic run_stream(int n, stream_kind_t kind);
    bit [7:0] stream_bytes [MAX_STREAM];
    int       len;
    int       at;
    int       j;
    len = book.active_len();
    for (int i = 0; i < n; i++) stream_bytes[i] = 8'($urandom);
    if (kind != STREAM_NOISE && n >= len) begin
      // Bias the start toward the final position so the match lands on the last byte.
      at = ($urandom_range(0, 2) == 0) ? n - len : $urandom_range(0, n - len);
      for (int p = 0; p < len; p++)
        if (book.care[p]) stream_bytes[at+p] = book.pattern[8*p +: 8];
      if (kind == STREAM_NEAR_MISS) begin
        j = $urandom_range(0, len - 1);
        stream_bytes[at+j] = stream_bytes[at+j] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < n; i++) send_byte(stream_bytes[i], i == n - 1);
    streams_sent++;
  endtask

  task automatic random_stream();
    int           len;
    int           n;
    int           pick;
    stream_kind_t kind;
    len  = book.active_len();
    pick = $urandom_range(0, 9);
    kind = (pick < 6) ? STREAM_PLANT : (pick < 8) ? STREAM_NEAR_MISS : STREAM_NOISE;
    // Mostly streams near the pattern size; now and then a long one.
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_STREAM)
                                    : $urandom_range(1, 2 * len + 6);
    run_stream(n, kind);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rx_stall_odds != 0 && $urandom_range(rx_stall_odds - 1, 0) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Check every accepted result request.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      book.match_result(out_match_found, out_match_address);
  end

  // Watchdog: end the run if no request moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[masked_byte_pattern_search] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase_goal;
    book          = new;
    book.clear_stream();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = 8'h00;
    in_last_byte  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_PATTERN_LOW;
    cfg_data      = '0;
    tx_gap_odds   = 6;
    rx_stall_odds = 6;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    streams_sent  = 0;
    cfg_writes    = 0;
    quiet_cycles  = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: length one, no care bits, so the first byte matches at address 0.
    run_stream(1, STREAM_NOISE);

    // Full sixteen-byte all-ones pattern at the top of the address space; the match
    // can only land on the last byte.
    await_drain();
    program_all('1, '1, 16'hFFFF, LENGTH_W'(16), '1);
    run_stream(16, STREAM_PLANT);

    // Length zero behaves as one: match a zero byte at the second position, then
    // ignore the rest of the stream.
    await_drain();
    program_all(64'h0, '1, 16'h0001, LENGTH_W'(0), '0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Length past the window is clipped to sixteen; a three-byte stream is too short.
    await_drain();
    program_all({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, LENGTH_W'(31),
                48'h123);
    run_stream(3, STREAM_NOISE);

    // Move the base address in the middle of a stream; the found address must use it.
    await_drain();
    program_all(64'h3412, 64'h0, 16'h0003, LENGTH_W'(2), '0);
    send_byte(8'h12, 1'b0);
    await_drain();
    cfg_write(REG_BASE_ADDRESS, 64'h1000);
    send_byte(8'h34, 1'b1);

    // Long receiver hold-off with single-byte streams that all match: fill the block
    // until it stalls the input.
    await_drain();
    program_all({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, LENGTH_W'(1),
                addr_t'({$urandom, $urandom}));
    tx_gap_odds = 0;
    hold_req    = 1'b1;
    repeat (30) run_stream(1, STREAM_NOISE);

    // Random phases: new settings each time, varied idling on both sides.
    while (bytes_sent < TARGET_BYTES - TAIL_BYTES) begin
      await_drain();
      random_config();
      case ($urandom_range(0, 2))
        0:       tx_gap_odds = 0;
        1:       tx_gap_odds = 4;
        default: tx_gap_odds = 12;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_odds = 0;
        1:       rx_stall_odds = 5;
        default: rx_stall_odds = 15;
      endcase
      phase_goal = bytes_sent + $urandom_range(60, 120);
      while (bytes_sent < phase_goal) random_stream();
    end

    // Tail: no idling on either side.
    await_drain();
    random_config();
    tx_gap_odds   = 0;
    rx_stall_odds = 0;
    while (bytes_sent < TARGET_BYTES) random_stream();
    await_drain();

    $display("covered %0d streams, %0d bytes, %0d register writes",
             streams_sent, bytes_sent, cfg_writes);
    $display("results checked: %0d found, %0d not found; %0d mismatches",
             book.found_seen, book.missing_seen, book.errors);
    if (book.errors == 0) begin
      $display("[masked_byte_pattern_search] OK");
    end else begin
      $display("[masked_byte_pattern_search] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/mbps_pkg.sv
design/mbps_front.sv
design/mbps_queue.sv
design/mbps_back.sv
design/masked_byte_pattern_search.sv
test/tb.sv
